FILE: hdl/sbsa_pkg.sv
package sbsa_pkg;

	localparam int NODES       = 16;
	localparam int BLK_ENTRIES = 9;
	localparam int VAL_W       = 32;
	localparam int NODE_W      = 4;
	localparam int THR_W       = 16;
	localparam int BLK_CNT     = NODES * NODES;
	localparam int BLK_W       = (BLK_CNT > 1) ? $clog2(BLK_CNT) : 1;
	localparam int BLK_BITS    = BLK_ENTRIES * VAL_W;

	localparam logic [THR_W-1:0] THR_RESET = 16'd1;

	localparam logic KIND_ACC  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [VAL_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] SAT_MIN = 32'h8000_0000;

	typedef logic [BLK_ENTRIES-1:0][VAL_W-1:0] blk_t;

	typedef struct packed {
		logic                    kind;
		logic [NODE_W-1:0]       row_node;
		logic [NODE_W-1:0]       col_node;
		logic signed [VAL_W-1:0] val_00;
		logic signed [VAL_W-1:0] val_01;
		logic signed [VAL_W-1:0] val_02;
		logic signed [VAL_W-1:0] val_10;
		logic signed [VAL_W-1:0] val_11;
		logic signed [VAL_W-1:0] val_12;
		logic signed [VAL_W-1:0] val_20;
		logic signed [VAL_W-1:0] val_21;
		logic signed [VAL_W-1:0] val_22;
	} item_t;

	typedef struct packed {
		logic                    skipped;
		logic                    saturated;
		logic signed [VAL_W-1:0] sum_00;
		logic signed [VAL_W-1:0] sum_01;
		logic signed [VAL_W-1:0] sum_02;
		logic signed [VAL_W-1:0] sum_10;
		logic signed [VAL_W-1:0] sum_11;
		logic signed [VAL_W-1:0] sum_12;
		logic signed [VAL_W-1:0] sum_20;
		logic signed [VAL_W-1:0] sum_21;
		logic signed [VAL_W-1:0] sum_22;
	} result_t;

endpackage

FILE: hdl/sbsa_ram.sv
module sbsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: hdl/sbsa_alu.sv
module sbsa_alu (
	input  sbsa_pkg::blk_t cur,
	input  sbsa_pkg::blk_t add,
	output sbsa_pkg::blk_t sum,
	output logic           sat
);
	import sbsa_pkg::*;

	logic [BLK_ENTRIES-1:0][VAL_W:0] wide;
	logic [BLK_ENTRIES-1:0]          clip;

	always_comb begin
		for (int k = 0; k < BLK_ENTRIES; k++) begin
			wide[k] = {cur[k][VAL_W-1], cur[k]} + {add[k][VAL_W-1], add[k]};
			clip[k] = wide[k][VAL_W] != wide[k][VAL_W-1];
			if (clip[k]) begin
				sum[k] = wide[k][VAL_W] ? SAT_MIN : SAT_MAX;
			end else begin
				sum[k] = wide[k][VAL_W-1:0];
			end
		end
	end

	assign sat = |clip;

endmodule

FILE: hdl/stiffness_block_scatter_accumulate.sv
// Accumulates 3x3 Q16.16 node-pair blocks into a global stiffness matrix that is
// held in one block-wide synchronous RAM, one row per (row node, column node) pair;
// the matrix reads as zero after reset through a per-block valid bit, so no clearing
// pass is needed. An accumulate beat whose entries all lie within plus or minus
// zero_threshold is skipped; otherwise each entry is added with saturation and the
// block is written back. A read beat returns the stored block. Each beat first reads
// the RAM, registered on acceptance, then does the add and write-back, which waits
// while a result is held at the output; the next beat is taken once the write-back
// is done, so a result may still wait at the output while the next beat is read.
module stiffness_block_scatter_accumulate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [sbsa_pkg::THR_W-1:0]        cfg_wr_data,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  sbsa_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output sbsa_pkg::result_t                 result
);
	import sbsa_pkg::*;

	logic [THR_W-1:0]   thr_q;
	logic [BLK_CNT-1:0] row_vld_q;

	logic               accept;
	logic               oor;
	logic               all_zero;
	logic [BLK_W-1:0]   blk_idx;
	logic signed [VAL_W-1:0] thr_pos;
	logic signed [VAL_W-1:0] thr_neg;
	blk_t               in_vals;

	logic               valid_s1;
	logic               kind_s1;
	logic               oor_s1;
	logic               zero_s1;
	logic               vld_s1;
	logic [BLK_W-1:0]   idx_s1;
	blk_t               vals_s1;

	logic [BLK_BITS-1:0] ram_rdata;
	blk_t               cur;
	blk_t               alu_sum;
	logic               alu_sat;
	logic               fire_s1;
	logic               ram_we;
	blk_t               out_blk;

	result_t            result_q;
	logic               result_valid_q;

	assign in_vals = {item.val_22, item.val_21, item.val_20,
		item.val_12, item.val_11, item.val_10,
		item.val_02, item.val_01, item.val_00};

	assign item_ready = !valid_s1;
	assign accept     = item_valid && item_ready;
	assign oor        = (int'(item.row_node) >= NODES) || (int'(item.col_node) >= NODES);
	assign blk_idx    = BLK_W'(int'(item.row_node) * NODES + int'(item.col_node));
	assign thr_pos    = $signed({{(VAL_W-THR_W){1'b0}}, thr_q});
	assign thr_neg    = -thr_pos;

	always_comb begin
		all_zero = 1'b1;
		for (int k = 0; k < BLK_ENTRIES; k++) begin
			if ($signed(in_vals[k]) < thr_neg || $signed(in_vals[k]) > thr_pos) begin
				all_zero = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= item.kind;
			oor_s1  <= oor;
			zero_s1 <= all_zero;
			vld_s1  <= oor ? 1'b0 : row_vld_q[blk_idx];
			idx_s1  <= blk_idx;
			vals_s1 <= in_vals;
		end
	end

	sbsa_ram #(
		.WIDTH(BLK_BITS),
		.DEPTH(BLK_CNT)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(idx_s1),
		.wr_data(alu_sum),
		.rd_en  (accept),
		.rd_addr(blk_idx),
		.rd_data(ram_rdata)
	);

	assign cur = vld_s1 ? blk_t'(ram_rdata) : '0;

	sbsa_alu u_alu (
		.cur(cur),
		.add(vals_s1),
		.sum(alu_sum),
		.sat(alu_sat)
	);

	assign fire_s1 = valid_s1 && (!result_valid_q || result_ready);
	assign ram_we  = fire_s1 && (kind_s1 == KIND_ACC) && !oor_s1 && !zero_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (ram_we) begin
			row_vld_q[idx_s1] <= 1'b1;
		end
	end

	always_comb begin
		if (oor_s1) begin
			out_blk = '0;
		end else if (ram_we) begin
			out_blk = alu_sum;
		end else begin
			out_blk = cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			result_q.skipped   <= (kind_s1 == KIND_ACC) && (oor_s1 || zero_s1);
			result_q.saturated <= ram_we && alu_sat;
			result_q.sum_00    <= out_blk[0];
			result_q.sum_01    <= out_blk[1];
			result_q.sum_02    <= out_blk[2];
			result_q.sum_10    <= out_blk[3];
			result_q.sum_11    <= out_blk[4];
			result_q.sum_12    <= out_blk[5];
			result_q.sum_20    <= out_blk[6];
			result_q.sum_21    <= out_blk[7];
			result_q.sum_22    <= out_blk[8];
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_we_only_acc: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> valid_s1 && kind_s1 == KIND_ACC && !oor_s1)
		else $error("store written for a beat that must not write");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.skipped && result.saturated))
		else $error("result both skipped and saturated");

	a_read_flags: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && kind_s1 == KIND_READ |=> !result.skipped && !result.saturated)
		else $error("read beat returned flags");

	a_vld_set: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> row_vld_q[$past(idx_s1)])
		else $error("block valid bit not set after write-back");

endmodule

FILE: verif/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sbsa_pkg::*;

	typedef logic signed [VAL_W-1:0] val_blk_t [BLK_ENTRIES];

	typedef enum int {
		RX_FREE,
		RX_SPARSE,
		RX_PERIODIC,
		RX_COIN
	} rx_mode_t;

	localparam logic signed [VAL_W+1:0] Q_MAX = 34'sd2147483647;
	localparam logic signed [VAL_W+1:0] Q_MIN = -34'sd2147483648;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [THR_W-1:0] cfg_wr_data = '0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;

	logic signed [VAL_W-1:0] stiffness_mirror [BLK_CNT][BLK_ENTRIES] = '{default: '0};
	logic [THR_W-1:0] zero_thr = THR_RESET;
	result_t pending_sums [$];

	int err_count = 0;
	int sent_count = 0;
	int results_seen = 0;
	int read_beats = 0;
	int skipped_beats = 0;
	int saturated_beats = 0;
	int thr_settings = 1;
	int burst_left = 0;
	int idle_cycles = 0;
	bit sender_gaps = 1'b1;
	bit hold_req = 1'b0;
	int hold_left = 0;
	rx_mode_t rx_mode = RX_FREE;
	int rx_left = 0;
	int rx_tick = 0;

	stiffness_block_scatter_accumulate dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic val_blk_t sums_of(result_t r);
		sums_of = '{r.sum_00, r.sum_01, r.sum_02, r.sum_10, r.sum_11, r.sum_12,
			r.sum_20, r.sum_21, r.sum_22};
	endfunction

	function automatic item_t make_item(logic kind, int row, int col, val_blk_t v);
		item_t it;
		it.kind = kind;
		it.row_node = NODE_W'(row);
		it.col_node = NODE_W'(col);
		{it.val_00, it.val_01, it.val_02, it.val_10, it.val_11, it.val_12,
			it.val_20, it.val_21, it.val_22} = {v[0], v[1], v[2], v[3], v[4], v[5],
			v[6], v[7], v[8]};
		return it;
	endfunction

	function automatic val_blk_t single_entry(int k, logic signed [VAL_W-1:0] x);
		val_blk_t v;
		v = '{default: '0};
		v[k] = x;
		return v;
	endfunction

	function automatic result_t predict_block_sum(item_t it);
		result_t r;
		val_blk_t v;
		logic signed [VAL_W+1:0] s;
		logic signed [VAL_W+1:0] lim;
		int b;
		bit quiet;
		r = '0;
		v = '{it.val_00, it.val_01, it.val_02, it.val_10, it.val_11, it.val_12,
			it.val_20, it.val_21, it.val_22};
		if (int'(it.row_node) >= NODES || int'(it.col_node) >= NODES) begin
			r.skipped = (it.kind == KIND_ACC);
			return r;
		end
		b = int'(it.row_node) * NODES + int'(it.col_node);
		lim = 34'(zero_thr);
		if (it.kind == KIND_ACC) begin
			quiet = 1'b1;
			for (int k = 0; k < BLK_ENTRIES; k++) begin
				if (v[k] > lim || v[k] < -lim)
					quiet = 1'b0;
			end
			if (quiet) begin
				r.skipped = 1'b1;
			end else begin
				for (int k = 0; k < BLK_ENTRIES; k++) begin
					s = 34'(v[k]) + 34'(stiffness_mirror[b][k]);
					if (s > Q_MAX) begin
						s = Q_MAX;
						r.saturated = 1'b1;
					end else if (s < Q_MIN) begin
						s = Q_MIN;
						r.saturated = 1'b1;
					end
					stiffness_mirror[b][k] = s[VAL_W-1:0];
				end
			end
		end
		{r.sum_00, r.sum_01, r.sum_02, r.sum_10, r.sum_11, r.sum_12, r.sum_20, r.sum_21,
			r.sum_22} = {stiffness_mirror[b][0], stiffness_mirror[b][1],
			stiffness_mirror[b][2], stiffness_mirror[b][3], stiffness_mirror[b][4],
			stiffness_mirror[b][5], stiffness_mirror[b][6], stiffness_mirror[b][7],
			stiffness_mirror[b][8]};
		return r;
	endfunction

	function automatic item_t random_item();
		val_blk_t v;
		int t;
		int pick;
		int row;
		int col;
		int k;
		logic kind;
		t = int'(zero_thr);
		kind = ($urandom_range(0, 3) == 0) ? KIND_READ : KIND_ACC;
		if ($urandom_range(0, 9) < 7) begin
			row = $urandom_range(0, 2);
			col = $urandom_range(0, 2);
		end else begin
			row = $urandom_range(0, NODES - 1);
			col = $urandom_range(0, NODES - 1);
		end
		pick = $urandom_range(0, 19);
		for (int i = 0; i < BLK_ENTRIES; i++) begin
			if (pick < 5)
				v[i] = $urandom_range(0, 2 * t) - t;
			else if (pick < 11)
				v[i] = $urandom;
			else if (pick < 16)
				v[i] = $urandom_range(0, 1 << 21) - (1 << 20);
			else begin
				case ($urandom_range(0, 4))
					0: v[i] = SAT_MAX;
					1: v[i] = SAT_MIN;
					2: v[i] = 32'sh4000_0000;
					3: v[i] = -32'sh4000_0000;
					default: v[i] = $urandom;
				endcase
			end
		end
		if (pick >= 3 && pick < 5) begin
			k = $urandom_range(0, BLK_ENTRIES - 1);
			v[k] = $urandom_range(0, 1) ? t + 1 : -(t + 1);
		end
		return make_item(kind, row, col, v);
	endfunction

	task automatic report_mismatch(string msg);
		err_count++;
		if (err_count <= 50)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic send_item(item_t it);
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sent_count++;
		if (sender_gaps) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 8))
					@(posedge clk);
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) :
					$urandom_range(0, 10);
			end
		end
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (results_seen != sent_count)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_threshold(logic [THR_W-1:0] v);
		wait_idle();
		cfg_wr_data <= v;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		zero_thr = v;
		thr_settings++;
	endtask

	task automatic test_reset_state();
		send_item(make_item(KIND_READ, 0, 0, '{default: '0}));
		send_item(make_item(KIND_READ, 15, 15, '{default: '0}));
		send_item(make_item(KIND_READ, 0, 15, '{default: '0}));
	endtask

	task automatic test_skip_rule();
		send_item(make_item(KIND_ACC, 1, 2, '{default: '0}));
		send_item(make_item(KIND_ACC, 1, 2, '{1, -1, 1, -1, 1, -1, 1, -1, 1}));
		send_item(make_item(KIND_ACC, 1, 2, single_entry(4, 2)));
		send_item(make_item(KIND_ACC, 1, 2, single_entry(8, -2)));
		send_item(make_item(KIND_READ, 1, 2, '{default: '0}));
	endtask

	task automatic test_saturation();
		val_blk_t mixed;
		mixed = '{SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN,
			SAT_MAX};
		send_item(make_item(KIND_ACC, 3, 4, '{default: SAT_MAX}));
		send_item(make_item(KIND_ACC, 3, 4, '{default: 1}));
		send_item(make_item(KIND_ACC, 3, 4, '{default: SAT_MIN}));
		send_item(make_item(KIND_ACC, 3, 4, '{default: SAT_MIN}));
		send_item(make_item(KIND_ACC, 3, 4, '{default: '0}));
		send_item(make_item(KIND_READ, 4, 3, '{default: '0}));
		send_item(make_item(KIND_ACC, 5, 6, mixed));
		send_item(make_item(KIND_ACC, 5, 6, mixed));
	endtask

	task automatic test_threshold_extremes();
		write_threshold('0);
		send_item(make_item(KIND_ACC, 9, 9, '{default: '0}));
		send_item(make_item(KIND_ACC, 9, 9, single_entry(0, 1)));
		write_threshold('1);
		send_item(make_item(KIND_ACC, 9, 9, '{65535, -65535, 65535, -65535, 65535, -65535,
			65535, -65535, 65535}));
		send_item(make_item(KIND_ACC, 9, 9, single_entry(3, 65536)));
	endtask

	task automatic test_same_block_streak();
		item_t it;
		sender_gaps = 1'b0;
		for (int i = 0; i < 30; i++) begin
			it = random_item();
			it.row_node = NODE_W'(7);
			it.col_node = NODE_W'((i % 3 == 0) ? 8 : 7);
			send_item(it);
		end
		sender_gaps = 1'b1;
		wait_idle();
	endtask

	task automatic test_output_backpressure();
		sender_gaps = 1'b0;
		hold_req = 1'b1;
		for (int i = 0; i < 60; i++)
			send_item(random_item());
		sender_gaps = 1'b1;
		wait_idle();
	endtask

	task automatic test_random_traffic(int n);
		for (int i = 0; i < n; i++)
			send_item(random_item());
		wait_idle();
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 300);
		end else begin
			rx_left--;
		end
		rx_tick++;
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_FREE: result_ready <= 1'b1;
				RX_SPARSE: result_ready <= ($urandom_range(0, 3) != 0);
				RX_PERIODIC: result_ready <= (rx_tick % 5 < 2);
				default: result_ready <= ($urandom_range(0, 1) == 1);
			endcase
		end
	end

	always @(posedge clk) begin : beat_checker
		result_t want;
		val_blk_t got_s;
		val_blk_t want_s;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				want = predict_block_sum(item);
				pending_sums.push_back(want);
				if (item.kind == KIND_READ)
					read_beats++;
				if (want.skipped)
					skipped_beats++;
				if (want.saturated)
					saturated_beats++;
			end
			if (result_valid && result_ready) begin
				results_seen++;
				if (pending_sums.size() == 0) begin
					report_mismatch($sformatf("result beat %0d arrived with nothing expected",
						results_seen));
				end else begin
					want = pending_sums.pop_front();
					if (result.skipped !== want.skipped)
						report_mismatch($sformatf("beat %0d skipped got %0b want %0b",
							results_seen, result.skipped, want.skipped));
					if (result.saturated !== want.saturated)
						report_mismatch($sformatf("beat %0d saturated got %0b want %0b",
							results_seen, result.saturated, want.saturated));
					got_s = sums_of(result);
					want_s = sums_of(want);
					for (int k = 0; k < BLK_ENTRIES; k++) begin
						if (got_s[k] !== want_s[k])
							report_mismatch($sformatf("beat %0d sum_%0d%0d got %h want %h",
								results_seen, k / 3, k % 3, got_s[k], want_s[k]));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("No beat moved for %0d cycles; stopping.", WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_skip_rule();
		test_saturation();
		test_threshold_extremes();
		test_same_block_streak();
		test_output_backpressure();
		test_random_traffic(380);
		write_threshold(THR_W'($urandom_range(2, 65534)));
		test_random_traffic(400);
		write_threshold('0);
		test_random_traffic(400);
		write_threshold(THR_RESET);
		test_random_traffic(400);
		wait_idle();
		repeat (10)
			@(posedge clk);
		if (pending_sums.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_sums.size()));
		$display("Sent %0d block beats (%0d reads) under %0d threshold settings.",
			sent_count, read_beats, thr_settings);
		$display("Saw %0d skipped and %0d saturating results, %0d mismatches.",
			skipped_beats, saturated_beats, err_count);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/sbsa_pkg.sv
hdl/sbsa_ram.sv
hdl/sbsa_alu.sv
hdl/stiffness_block_scatter_accumulate.sv
verif/tb_top.sv
